// ===== design/hbp_pkg.sv =====
package hbp_pkg;

  localparam int unsigned MaxCodeLenDef  = 32;
  localparam int unsigned SymbolCountDef = 256;

  localparam int unsigned OpW      = 2;
  localparam int unsigned SymW     = 8;
  localparam int unsigned CodeInW  = 32;
  localparam int unsigned LenInW   = 6;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PendW    = 7;
  localparam int unsigned PendCntW = 3;

  typedef enum logic [OpW-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

endpackage

// ===== design/huffman_bit_packer_unit.sv =====
// huffman bit packer: byte symbols in, packed huffman bitstream bytes out
// input channel: in_valid_i / in_stall_o with op, symbol, code_bits, code_length.
//   load writes one code table entry, encode appends the symbol's code,
//   flush pads pending bits with zeros to a whole byte
// output channel: out_valid_o / out_stall_i with packed_byte and last_of_run;
//   last_of_run marks the final byte produced by one input transaction
// an accepted item first has its code table entry read into a register, then its
//   bytes are assembled into the output hold register, from which they are sent
// throughput: one item per cycle while each item yields at most one byte and the
//   receiver does not stall; the output hold register sends one byte per cycle,
//   so an item yielding several bytes holds back the next until its last is sent
// a symbol with no code, a load, an unused op and an empty flush yield nothing
// reset clears the pending bits and marks every table entry as having no code;
//   no clearing pass is needed, the block accepts items right after reset
// while the receiver stalls, bytes stay in the hold register and one more item
//   waits in the assembly stage, then in_stall_o rises
module huffman_bit_packer_unit
  import hbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_LEN = MaxCodeLenDef,
  parameter int unsigned SYMBOL_COUNT = SymbolCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OpW-1:0]     op_i,
  input  logic [SymW-1:0]    symbol_i,
  input  logic [CodeInW-1:0] code_bits_i,
  input  logic [LenInW-1:0]  code_length_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   packed_byte_o,
  output logic               last_of_run_o
);

  localparam int unsigned LenLimit  = (MAX_CODE_LEN < CodeInW) ? MAX_CODE_LEN : CodeInW;
  localparam int unsigned LenW      = $clog2(LenLimit + 1);
  localparam int unsigned EntryW    = LenLimit + LenW;
  localparam int unsigned AddrW     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int unsigned AccW      = LenLimit + PendW;
  localparam int unsigned TotW      = $clog2(AccW + 1);
  localparam int unsigned MaxBytes  = AccW / ByteW;
  localparam int unsigned CntW      = $clog2(MaxBytes + 1);

  // input side
  logic              accept;
  logic              in_table;
  logic [AddrW-1:0]  addr;
  logic [LenInW-1:0] len_clamped;
  logic [CodeInW:0]  len_mask;
  logic [LenLimit-1:0] code_masked;
  logic              load_we;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_table = {1'b0, symbol_i} < (SymW + 1)'(SYMBOL_COUNT);
  assign addr     = symbol_i[AddrW-1:0];

  always_comb begin
    len_clamped = (code_length_i > LenInW'(LenLimit)) ? LenInW'(LenLimit) : code_length_i;
    len_mask    = ((CodeInW + 1)'(1) << len_clamped) - (CodeInW + 1)'(1);
    code_masked = LenLimit'(code_bits_i & len_mask[CodeInW-1:0]);
  end

  assign load_we = accept && (op_e'(op_i) == OP_LOAD) && in_table;

  logic [SYMBOL_COUNT-1:0] ent_valid_q;
  logic [EntryW-1:0]       rd_entry;

  hbp_ram #(
    .WIDTH  (EntryW),
    .DEPTH  (SYMBOL_COUNT),
    .ADDR_W (AddrW)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (addr),
    .wdata_i ({LenW'(len_clamped), code_masked}),
    .re_i    (accept),
    .raddr_i (addr),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
    end else if (load_we) begin
      ent_valid_q[addr] <= 1'b1;
    end
  end

  // assembly stage
  logic               s1_valid_q;
  logic               s1_valid_d;
  op_e                s1_op_q;
  logic               s1_in_table_q;
  logic               s1_ent_valid_q;
  logic [PendW-1:0]   pend_bits_q;
  logic [PendW-1:0]   pend_bits_d;
  logic [PendCntW-1:0] pend_cnt_q;
  logic [PendCntW-1:0] pend_cnt_d;

  logic [LenW-1:0]      clen;
  logic [LenLimit-1:0]  rd_code;
  logic                 encoding;
  logic                 flushing;
  logic [AccW-1:0]      acc;
  logic [AccW-1:0]      win;
  logic [TotW-1:0]      total;
  logic [CntW-1:0]      enc_n;
  logic [CntW-1:0]      s1_n;
  logic [ByteW-1:0]     s1_bytes [MaxBytes];
  logic [ByteW-1:0]     flush_byte;
  logic                 s1_fire;
  logic                 hold_free;

  assign rd_code  = rd_entry[LenLimit-1:0];
  assign clen     = s1_ent_valid_q ? rd_entry[EntryW-1:LenLimit] : '0;
  assign encoding = (s1_op_q == OP_ENCODE) && s1_in_table_q && (clen != '0);
  assign flushing = (s1_op_q == OP_FLUSH) && (pend_cnt_q != '0);

  always_comb begin
    acc        = (AccW'(pend_bits_q) << clen) | AccW'(rd_code);
    total      = TotW'(pend_cnt_q) + TotW'(clen);
    win        = acc << (TotW'(AccW) - total);
    enc_n      = CntW'(total >> 3);
    flush_byte = ByteW'({1'b0, pend_bits_q} << (4'd8 - {1'b0, pend_cnt_q}));
    for (int k = 0; k < MaxBytes; k++) begin
      s1_bytes[k] = win[AccW-1-ByteW*k -: ByteW];
    end
    if (flushing) begin
      s1_bytes[0] = flush_byte;
    end
    if (encoding) begin
      s1_n = enc_n;
    end else if (flushing) begin
      s1_n = CntW'(1);
    end else begin
      s1_n = '0;
    end
  end

  assign s1_fire    = s1_valid_q && ((s1_n == '0) || hold_free);
  assign in_stall_o = s1_valid_q && !s1_fire;

  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    if (s1_fire) begin
      if (encoding) begin
        pend_cnt_d  = total[PendCntW-1:0];
        pend_bits_d = acc[PendW-1:0] &
                      ((PendW'(1) << total[PendCntW-1:0]) - PendW'(1));
      end else if (flushing) begin
        pend_cnt_d  = '0;
        pend_bits_d = '0;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q        <= op_e'(op_i);
      s1_in_table_q  <= in_table;
      s1_ent_valid_q <= ent_valid_q[addr];
    end
  end

  // output hold register
  logic [ByteW-1:0] hold_bytes_q [MaxBytes];
  logic [ByteW-1:0] hold_bytes_d [MaxBytes];
  logic [CntW-1:0]  hold_cnt_q;
  logic [CntW-1:0]  hold_cnt_d;
  logic             pop;

  assign pop       = (hold_cnt_q != '0) && !out_stall_i;
  assign hold_free = (hold_cnt_q == '0) || ((hold_cnt_q == CntW'(1)) && pop);

  always_comb begin
    hold_bytes_d = hold_bytes_q;
    hold_cnt_d   = hold_cnt_q;
    if (s1_fire && (s1_n != '0)) begin
      hold_bytes_d = s1_bytes;
      hold_cnt_d   = s1_n;
    end else if (pop) begin
      for (int k = 0; k < MaxBytes - 1; k++) begin
        hold_bytes_d[k] = hold_bytes_q[k+1];
      end
      hold_cnt_d = hold_cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt_q <= '0;
    end else begin
      hold_cnt_q <= hold_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_bytes_q <= hold_bytes_d;
  end

  assign out_valid_o   = hold_cnt_q != '0;
  assign packed_byte_o = hold_bytes_q[0];
  assign last_of_run_o = hold_cnt_q == CntW'(1);

endmodule

// ===== design/hbp_ram.sv =====
module hbp_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
